>>> rtl/kyber_pkg.sv
// ----------------------------------------------------------------------------
// kyber_pkg
// Shared constants, item mode codes and twiddle tables for the Kyber NTT engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kyber_pkg;

  localparam int POLY_LENGTH = 256;
  localparam int ADDR_W      = $clog2(POLY_LENGTH);
  localparam int COEF_W      = 16;
  localparam int MUL_W       = 17;
  localparam int PROD_W      = 32;

  localparam logic signed [MUL_W-1:0] MODULUS_Q    = 17'sd3329;
  localparam logic signed [MUL_W-1:0] Q_INVERSE    = 17'sd62209;
  localparam logic signed [MUL_W-1:0] BARRETT_MULT = 17'sd20159;
  localparam int                      BARRETT_SHIFT = 26;
  localparam logic signed [COEF_W-1:0] INV_SCALE   = 16'sd1441;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_INV   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // forward roots, 2^16 * 17^brv7(i) mod q, centered
  localparam logic signed [COEF_W-1:0] FWD_ZETA [128] = '{
    -16'sd1044, -16'sd758,  -16'sd359,  -16'sd1517,  16'sd1493,  16'sd1422,  16'sd287,
     16'sd202,  -16'sd171,   16'sd622,   16'sd1577,  16'sd182,   16'sd962,  -16'sd1202,
    -16'sd1474,  16'sd1468,  16'sd573,  -16'sd1325,  16'sd264,   16'sd383,  -16'sd829,
     16'sd1458, -16'sd1602, -16'sd130,  -16'sd681,   16'sd1017,  16'sd732,   16'sd608,
    -16'sd1542,  16'sd411,  -16'sd205,  -16'sd1571,  16'sd1223,  16'sd652,  -16'sd552,
     16'sd1015, -16'sd1293,  16'sd1491, -16'sd282,  -16'sd1544,  16'sd516,  -16'sd8,
    -16'sd320,  -16'sd666,  -16'sd1618, -16'sd1162,  16'sd126,   16'sd1469, -16'sd853,
    -16'sd90,   -16'sd271,   16'sd830,   16'sd107,  -16'sd1421, -16'sd247,  -16'sd951,
    -16'sd398,   16'sd961,  -16'sd1508, -16'sd725,   16'sd448,  -16'sd1065,  16'sd677,
    -16'sd1275, -16'sd1103,  16'sd430,   16'sd555,   16'sd843,  -16'sd1251,  16'sd871,
     16'sd1550,  16'sd105,   16'sd422,   16'sd587,   16'sd177,  -16'sd235,  -16'sd291,
    -16'sd460,   16'sd1574,  16'sd1653, -16'sd246,   16'sd778,   16'sd1159, -16'sd147,
    -16'sd777,   16'sd1483, -16'sd602,   16'sd1119, -16'sd1590,  16'sd644,  -16'sd872,
     16'sd349,   16'sd418,   16'sd329,  -16'sd156,  -16'sd75,    16'sd817,   16'sd1097,
     16'sd603,   16'sd610,   16'sd1322, -16'sd1285, -16'sd1465,  16'sd384,  -16'sd1215,
    -16'sd136,   16'sd1218, -16'sd1335, -16'sd874,   16'sd220,  -16'sd1187, -16'sd1659,
    -16'sd1185, -16'sd1530, -16'sd1278,  16'sd794,  -16'sd1510, -16'sd854,  -16'sd870,
     16'sd478,  -16'sd108,  -16'sd308,   16'sd996,   16'sd991,   16'sd958,  -16'sd1460,
     16'sd1522,  16'sd1628
  };

  // inverse roots are the negated forward roots in reverse order; index 127 gives INV_SCALE instead
  function automatic logic signed [COEF_W-1:0] inv_zeta(input logic [6:0] k);
    logic [6:0] rk;
    rk = 7'd127 - k;
    if (k == 7'd127) begin
      return INV_SCALE;
    end
    return -FWD_ZETA[rk];
  endfunction

endpackage

`default_nettype wire

>>> rtl/kyber_coef_mem.sv
// ----------------------------------------------------------------------------
// kyber_coef_mem
// Coefficient buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module kyber_coef_mem (
  input  wire                                       clk,
  input  wire                                       we,
  input  wire  [kyber_pkg::ADDR_W-1:0]              wr_addr,
  input  wire  logic signed [kyber_pkg::COEF_W-1:0] wr_data,
  input  wire                                       rd_en,
  input  wire  [kyber_pkg::ADDR_W-1:0]              rd_addr_a,
  input  wire  [kyber_pkg::ADDR_W-1:0]              rd_addr_b,
  output logic signed [kyber_pkg::COEF_W-1:0]       rd_data_a,
  output logic signed [kyber_pkg::COEF_W-1:0]       rd_data_b
);
  import kyber_pkg::*;

  logic signed [COEF_W-1:0] mem [POLY_LENGTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> rtl/kyber_mul_unit.sv
// ----------------------------------------------------------------------------
// kyber_mul_unit
// Shared signed 17x17 multiplier with a registered 32-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module kyber_mul_unit (
  input  wire                                      clk,
  input  wire                                      en,
  input  wire  logic signed [kyber_pkg::MUL_W-1:0] op_a,
  input  wire  logic signed [kyber_pkg::MUL_W-1:0] op_b,
  output logic signed [kyber_pkg::PROD_W-1:0]      prod_r
);
  import kyber_pkg::*;

  logic signed [2*MUL_W-1:0] prod_full;

  assign prod_full = op_a * op_b;

  // only the low 32 bits of any product are ever used
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/kyber_ntt_engine_top.sv
// ----------------------------------------------------------------------------
// kyber_ntt_engine_top
// 256-entry coefficient buffer with in-place forward / inverse Kyber NTT.
//
// channel   dir   handshake             payload
// in_       in    in_valid / in_ready   in_mode, in_index, in_coefficient
// out_      out   out_valid / out_ready out_value, out_done_res
//
// a write completes on acceptance; a read passes through S_RDOUT before its value is posted
// a transform runs 896 butterflies, each through S_RD, S_B1 and S_B2 (inverse only), S_MA,
// S_R1, S_R2, S_R3, S_WA and S_WB, then S_DONE posts the result,
// bound by the single shared multiplier and the single buffer write port
// in_ready is low while an item is in progress or a result is held and not taken
// rst_n clears control state only; buffer contents stay undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module kyber_ntt_engine_top (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire  [1:0]                                in_mode,
  input  wire  [kyber_pkg::ADDR_W-1:0]              in_index,
  input  wire  logic signed [kyber_pkg::COEF_W-1:0] in_coefficient,
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output logic signed [kyber_pkg::COEF_W-1:0]       out_value,
  output logic                                      out_done_res
);
  import kyber_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDOUT = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_B1    = 12'b000000001000,
    S_B2    = 12'b000000010000,
    S_MA    = 12'b000000100000,
    S_R1    = 12'b000001000000,
    S_R2    = 12'b000010000000,
    S_R3    = 12'b000100000000,
    S_WA    = 12'b001000000000,
    S_WB    = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic               is_inv_r, is_inv_nxt;
  logic [ADDR_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0]  start_r, start_nxt;
  logic [ADDR_W-2:0]  off_r, off_nxt;
  logic [6:0]         k_r, k_nxt;

  logic signed [COEF_W-1:0] s_r, s_nxt;
  logic signed [COEF_W-1:0] d_r, d_nxt;
  logic signed [COEF_W-1:0] t_r, t_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [COEF_W-1:0] out_value_r, out_value_nxt;
  logic                     out_done_r, out_done_nxt;

  logic                     in_acc;
  logic [ADDR_W-1:0]        addr_a, addr_b;
  logic [ADDR_W:0]          grp_next;
  logic                     last_off, last_layer;

  logic                     we, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr_a;
  logic signed [COEF_W-1:0] wr_data, ra, rb;
  logic signed [COEF_W-1:0] s_now, d_now, zeta;
  logic signed [PROD_W-1:0] prod_r, mont_diff;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_done_res = out_done_r;

  assign addr_a   = start_r + {1'b0, off_r};
  assign addr_b   = addr_a + len_r;
  assign grp_next = {1'b0, start_r} + {len_r, 1'b0};
  assign last_off = ({1'b0, off_r} + 8'd1) == len_r;
  assign last_layer = is_inv_r ? (len_r == 8'd128) : (len_r == 8'd2);

  assign s_now = ra + rb;
  assign d_now = ra - rb;
  assign zeta  = is_inv_r ? inv_zeta(k_r) : FWD_ZETA[k_r];
  assign mont_diff = acc_r - prod_r;

  kyber_coef_mem u_mem (
    .clk       (clk),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (ra),
    .rd_data_b (rb)
  );

  kyber_mul_unit u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // buffer port control
  always_comb begin
    we        = 1'b0;
    wr_addr   = in_index;
    wr_data   = in_coefficient;
    rd_en     = 1'b0;
    rd_addr_a = addr_a;
    case (state_r)
      S_IDLE: begin
        we        = in_acc && (in_mode == MODE_WRITE);
        rd_en     = in_acc && (in_mode == MODE_READ);
        rd_addr_a = in_index;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_WA: begin
        we      = 1'b1;
        wr_addr = addr_a;
        wr_data = is_inv_r ? s_r : ra + t_r;
      end
      S_WB: begin
        we      = 1'b1;
        wr_addr = addr_b;
        wr_data = is_inv_r ? t_r : ra - t_r;
      end
      default: begin
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_B1: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(s_now);
        mul_b  = BARRETT_MULT;
      end
      S_B2: begin
        // barrett quotient, floor of product over 2^26
        mul_en = 1'b1;
        mul_a  = MUL_W'($signed(prod_r[PROD_W-1:BARRETT_SHIFT]));
        mul_b  = MODULUS_Q;
      end
      S_MA: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(zeta);
        mul_b  = MUL_W'(is_inv_r ? d_r : rb);
      end
      S_R1: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, prod_r[COEF_W-1:0]};
        mul_b  = Q_INVERSE;
      end
      S_R2: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'($signed(prod_r[COEF_W-1:0]));
        mul_b  = MODULUS_Q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    is_inv_nxt    = is_inv_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    off_nxt       = off_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          start_nxt = '0;
          off_nxt   = '0;
          case (in_mode)
            MODE_WRITE: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_done_nxt  = 1'b0;
            end
            MODE_READ: begin
              state_nxt = S_RDOUT;
            end
            MODE_FWD: begin
              state_nxt  = S_RD;
              is_inv_nxt = 1'b0;
              len_nxt    = 8'd128;
              k_nxt      = 7'd1;
            end
            default: begin
              state_nxt  = S_RD;
              is_inv_nxt = 1'b1;
              len_nxt    = 8'd2;
              k_nxt      = 7'd0;
            end
          endcase
        end
      end
      S_RDOUT: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_value_nxt = ra;
        out_done_nxt  = 1'b0;
      end
      S_RD: begin
        state_nxt = is_inv_r ? S_B1 : S_MA;
      end
      S_B1: begin
        s_nxt     = s_now;
        d_nxt     = d_now;
        state_nxt = S_B2;
      end
      S_B2: begin
        state_nxt = S_MA;
      end
      S_MA: begin
        if (is_inv_r) begin
          s_nxt = s_r - prod_r[COEF_W-1:0];
        end
        state_nxt = S_R1;
      end
      S_R1: begin
        acc_nxt   = prod_r;
        state_nxt = S_R2;
      end
      S_R2: begin
        state_nxt = S_R3;
      end
      S_R3: begin
        // exact division by 2^16
        t_nxt     = mont_diff[PROD_W-1:COEF_W];
        state_nxt = S_WA;
      end
      S_WA: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = S_RD;
        off_nxt   = off_r + 7'd1;
        if (last_off) begin
          off_nxt   = '0;
          k_nxt     = k_r + 7'd1;
          start_nxt = grp_next[ADDR_W-1:0];
          if (grp_next[ADDR_W]) begin
            start_nxt = '0;
            len_nxt   = is_inv_r ? {len_r[ADDR_W-2:0], 1'b0} : {1'b0, len_r[ADDR_W-1:1]};
            if (last_layer) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_value_nxt = '0;
        out_done_nxt  = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_inv_r    <= is_inv_nxt;
    len_r       <= len_nxt;
    start_r     <= start_nxt;
    off_r       <= off_nxt;
    k_r         <= k_nxt;
    s_r         <= s_nxt;
    d_r         <= d_nxt;
    t_r         <= t_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_transform_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_FWD || in_mode == MODE_INV) |=> state_r == S_RD)
    else $error("transform item did not start the butterfly loop");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_value == '0)
    else $error("transform result carries a nonzero value");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("item accepted while busy");

endmodule

`default_nettype wire
